[design/elfs_pkg.sv]
// Shared types, constants and byte-class functions for the escaped line field splitter.
`default_nettype none
package elfs_pkg;

    localparam int PENDING_DEPTH = 32;
    localparam int PEND_AW = $clog2(PENDING_DEPTH);
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
    localparam int PEND_EW = 9;

    localparam int CAP_W = 13;
    localparam int MAXF_W = 7;
    localparam int FIELD_W = 6;
    localparam logic [MAXF_W-1:0] FIELD_LIMIT_MAX = 7'd64;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_T = 8'h74;

    localparam logic REG_LINE_CAPACITY = 1'b0;
    localparam logic REG_MAX_FIELDS = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         value;
        logic [FIELD_W-1:0] field_index;
        logic               field_start;
        logic [MAXF_W-1:0]  field_count;
        logic               ovf;
        logic               last;
    } res_t;

    function automatic logic is_trim(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
               (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic [7:0] decode_esc(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LOW_R: r = CH_CR;
            CH_LOW_N: r = CH_LF;
            CH_LOW_T: r = CH_TAB;
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/escaped_line_field_splitter.sv]
// Top level: line chunking, escape decoding and field splitting sequencer.
//
// Usage: raw text bytes enter on the s_ stream (s_tdata = byte, s_tuser = end of
// input flag) and decoded items leave on the m_ stream (m_tuser = item kind,
// m_tlast on the last item caused by one input item). Line capacity and field
// limit are set through the write port cfg_wr_en / cfg_index / cfg_data while idle.
// One item is taken at a time; s_tready is low until all its items have been
// handed to the output register. An item is accepted, then each held
// trailing-whitespace byte that it releases costs one read of the pending store
// and one step of the shared field/flush unit, then come its own decoded byte,
// an end of line and the hand-over of the final item.
// A stalled receiver holds the output register; the sequencer then waits and
// resumes without loss. aresetn (synchronous, active low) clears the line state,
// loads line capacity 512 and field limit 16, and empties the output register.
// The pending store needs no clearing after reset.
`default_nettype none
module escaped_line_field_splitter
    import elfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,  // in_byte
    input  wire logic [0:0]        s_tuser,  // end_of_input
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,  // value, field_index, field_start, field_count, pending_overflow
    output logic [0:0]             m_tuser,  // item_kind
    output logic                   m_tlast,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CAP_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FL_RD,
        ST_FL_EX,
        ST_EMIT,
        ST_CLOSE,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [MAXF_W-1:0]  maxf_reg, maxf_next;
    logic [CAP_W-1:0]   line_pos_reg, line_pos_next;
    logic               comment_reg, comment_next;
    logic               content_reg, content_next;
    logic               esc_reg, esc_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [PEND_CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic               ovf_reg, ovf_next;
    logic               need_start_reg, need_start_next;
    logic               emit_reg, emit_next;
    logic [7:0]         emit_val_reg, emit_val_next;
    logic               close_reg, close_next;
    logic [PEND_AW-1:0] flush_idx_reg, flush_idx_next;
    logic               skip_reg, skip_next;
    logic               hold_valid_reg, hold_valid_next;
    res_t               hold_reg, hold_next;

    logic               out_free;
    logic               out_push;
    res_t               out_data;
    logic               mem_wr_en;
    logic [PEND_EW-1:0] mem_wr_data;
    logic [PEND_EW-1:0] mem_rd_data;

    logic [CAP_W-1:0]   cap_m1;
    logic [MAXF_W-1:0]  field_limit;
    logic [MAXF_W-1:0]  field_inc;
    logic               can_gen;

    assign cap_m1 = ((cap_reg < CAP_W'(2)) ? CAP_W'(2) : cap_reg) - CAP_W'(1);
    assign field_limit = (maxf_reg == '0) ? MAXF_W'(1) :
                         ((maxf_reg > FIELD_LIMIT_MAX) ? FIELD_LIMIT_MAX : maxf_reg);
    assign field_inc = {1'b0, field_reg} + MAXF_W'(1);
    assign can_gen = !hold_valid_reg || out_free;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        logic [7:0]         b;
        logic [CAP_W-1:0]   pos_inc;
        logic               do_flush;
        logic               do_push;
        logic               gen;
        res_t               gen_res;
        logic               fl_last;
        logic [7:0]         eb;
        logic               e_esc;
        logic               e_emit;

        state_next = state_reg;
        cap_next = cap_reg;
        maxf_next = maxf_reg;
        line_pos_next = line_pos_reg;
        comment_next = comment_reg;
        content_next = content_reg;
        esc_next = esc_reg;
        field_next = field_reg;
        pend_cnt_next = pend_cnt_reg;
        ovf_next = ovf_reg;
        need_start_next = need_start_reg;
        emit_next = emit_reg;
        emit_val_next = emit_val_reg;
        close_next = close_reg;
        flush_idx_next = flush_idx_reg;
        skip_next = skip_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;
        out_push = 1'b0;
        out_data = hold_reg;
        mem_wr_en = 1'b0;

        b = s_tdata;
        pos_inc = line_pos_reg + CAP_W'(1);
        do_flush = 1'b0;
        do_push = 1'b0;
        gen = 1'b0;
        gen_res = '0;
        fl_last = ({1'b0, flush_idx_reg} + PEND_CW'(1)) == pend_cnt_reg;
        eb = mem_rd_data[7:0];
        e_esc = mem_rd_data[8];
        e_emit = e_esc || !(is_sep(eb) && (skip_reg || (field_inc < field_limit)));
        mem_wr_data = {esc_reg, b};

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINE_CAPACITY: cap_next = cfg_data;
                REG_MAX_FIELDS:    maxf_next = cfg_data[MAXF_W-1:0];
                default:           cap_next = cap_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    emit_next = 1'b0;
                    emit_val_next = b;
                    if (s_tuser[0]) begin
                        close_next = (line_pos_reg != '0);
                    end else begin
                        line_pos_next = pos_inc;
                        if ((line_pos_reg == '0) && (b == CH_HASH)) begin
                            comment_next = 1'b1;
                        end else if (comment_reg || (b == CH_LF)) begin
                            comment_next = comment_reg;
                        end else if (b == CH_NUL) begin
                            comment_next = 1'b1;
                            pend_cnt_next = '0;
                            esc_next = 1'b0;
                        end else if (esc_reg) begin
                            esc_next = 1'b0;
                            if (is_trim(b)) begin
                                do_push = 1'b1;
                            end else begin
                                do_flush = 1'b1;
                                emit_next = 1'b1;
                                emit_val_next = decode_esc(b);
                            end
                        end else if (is_trim(b)) begin
                            do_push = content_reg;
                        end else begin
                            content_next = 1'b1;
                            do_flush = 1'b1;
                            if (b == CH_BSL) begin
                                esc_next = 1'b1;
                            end else begin
                                emit_next = 1'b1;
                            end
                        end
                        close_next = (b == CH_LF) || (pos_inc >= cap_m1);
                    end
                    if (do_push) begin
                        if (pend_cnt_reg < PEND_CW'(PENDING_DEPTH)) begin
                            mem_wr_en = 1'b1;
                            pend_cnt_next = pend_cnt_reg + PEND_CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    flush_idx_next = '0;
                    skip_next = 1'b0;
                    if (do_flush && (pend_cnt_reg != '0)) begin
                        state_next = ST_FL_RD;
                    end else if (emit_next) begin
                        state_next = ST_EMIT;
                    end else if (close_next) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_FL_RD: begin
                state_next = ST_FL_EX;
            end
            ST_FL_EX: begin
                if (!e_emit || can_gen) begin
                    if (e_esc) begin
                        gen = 1'b1;
                        skip_next = 1'b0;
                    end else if (is_sep(eb) && skip_reg) begin
                        skip_next = 1'b1;
                    end else if (is_sep(eb) && (field_inc < field_limit)) begin
                        field_next = field_inc[FIELD_W-1:0];
                        need_start_next = 1'b1;
                        skip_next = 1'b1;
                    end else begin
                        gen = 1'b1;
                        skip_next = 1'b0;
                    end
                    gen_res.kind = KIND_BYTE;
                    gen_res.value = eb;
                    gen_res.field_index = field_reg;
                    gen_res.field_start = need_start_reg;
                    gen_res.field_count = field_inc;
                    gen_res.ovf = ovf_reg;
                    if (gen) begin
                        need_start_next = 1'b0;
                    end
                    if (fl_last) begin
                        pend_cnt_next = '0;
                        if (emit_reg) begin
                            state_next = ST_EMIT;
                        end else if (close_reg) begin
                            state_next = ST_CLOSE;
                        end else if (hold_valid_reg || gen) begin
                            state_next = ST_DRAIN;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        flush_idx_next = flush_idx_reg + PEND_AW'(1);
                        state_next = ST_FL_RD;
                    end
                end
            end
            ST_EMIT: begin
                if (can_gen) begin
                    gen = 1'b1;
                    gen_res.kind = KIND_BYTE;
                    gen_res.value = emit_val_reg;
                    gen_res.field_index = field_reg;
                    gen_res.field_start = need_start_reg;
                    gen_res.field_count = field_inc;
                    gen_res.ovf = ovf_reg;
                    need_start_next = 1'b0;
                    state_next = close_reg ? ST_CLOSE : ST_DRAIN;
                end
            end
            ST_CLOSE: begin
                if (!content_reg || can_gen) begin
                    gen = content_reg;
                    gen_res.kind = KIND_EOL;
                    gen_res.value = '0;
                    gen_res.field_index = field_reg;
                    gen_res.field_start = 1'b0;
                    gen_res.field_count = field_inc;
                    gen_res.ovf = ovf_reg;
                    line_pos_next = '0;
                    comment_next = 1'b0;
                    content_next = 1'b0;
                    esc_next = 1'b0;
                    field_next = '0;
                    pend_cnt_next = '0;
                    ovf_next = 1'b0;
                    need_start_next = 1'b1;
                    state_next = (hold_valid_reg || gen) ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_data.last = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (gen) begin
            out_push = hold_valid_reg;
            out_data.last = 1'b0;
            gen_res.last = 1'b0;
            hold_next = gen_res;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg <= CAP_W'(512);
            maxf_reg <= MAXF_W'(16);
            line_pos_reg <= '0;
            comment_reg <= 1'b0;
            content_reg <= 1'b0;
            esc_reg <= 1'b0;
            field_reg <= '0;
            pend_cnt_reg <= '0;
            ovf_reg <= 1'b0;
            need_start_reg <= 1'b1;
            emit_reg <= 1'b0;
            emit_val_reg <= '0;
            close_reg <= 1'b0;
            flush_idx_reg <= '0;
            skip_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg <= '0;
        end else begin
            state_reg <= state_next;
            cap_reg <= cap_next;
            maxf_reg <= maxf_next;
            line_pos_reg <= line_pos_next;
            comment_reg <= comment_next;
            content_reg <= content_next;
            esc_reg <= esc_next;
            field_reg <= field_next;
            pend_cnt_reg <= pend_cnt_next;
            ovf_reg <= ovf_next;
            need_start_reg <= need_start_next;
            emit_reg <= emit_next;
            emit_val_reg <= emit_val_next;
            close_reg <= close_next;
            flush_idx_reg <= flush_idx_next;
            skip_reg <= skip_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg <= hold_next;
        end
    end

    elfs_pend_ram u_pend_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (pend_cnt_reg[PEND_AW-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (state_reg == ST_FL_RD),
        .rd_addr (flush_idx_reg),
        .rd_data (mem_rd_data)
    );

    elfs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_data (out_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg <= PEND_CW'(PENDING_DEPTH)) else $error("pending count beyond depth");
    a_ready_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !hold_valid_reg) else $error("item accepted with result still held");
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && out_free) |=> s_tready) else $error("drain did not finish");
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE && state_next != ST_CLOSE) |=>
        (pend_cnt_reg == '0 && line_pos_reg == '0)) else $error("line state not cleared");
`endif

endmodule
`default_nettype wire

[design/elfs_pend_ram.sv]
// Pending trailing-whitespace store: one write port, one registered read port.
`default_nettype none
module elfs_pend_ram
    import elfs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [PEND_AW-1:0] wr_addr,
    input  wire logic [PEND_EW-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [PEND_AW-1:0] rd_addr,
    output logic      [PEND_EW-1:0] rd_data
);

    logic [PEND_EW-1:0] mem [PENDING_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/elfs_out_reg.sv]
// Result output register: packs one result item onto the master stream.
`default_nettype none
module elfs_out_reg
    import elfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire res_t        push_data,
    output logic             free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // value, field_index, field_start, field_count, pending_overflow
    output logic [0:0]       m_tuser,  // item_kind
    output logic             m_tlast
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next = data_reg;
        if (push) begin
            valid_next = 1'b1;
            data_next = push_data;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            data_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {1'b0, data_reg.ovf, data_reg.field_count, data_reg.field_start,
                      data_reg.field_index, data_reg.value};
    assign m_tuser = data_reg.kind;
    assign m_tlast = data_reg.last;

`ifndef ASSERT_OFF
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> free) else $error("item pushed into occupied output register");
    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tvalid) else $error("pushed item not presented");
`endif

endmodule
`default_nettype wire
